>>> hdl/fgbp_pkg.sv
`default_nettype none
package fgbp_pkg;

    // Sizes of the fields and of the flow table.
    localparam int unsigned MAX_GRID_CELLS_DEF = 16384;
    localparam int unsigned COORD_FRAC_BITS    = 16;
    localparam int unsigned COORD_W            = 17;
    localparam int unsigned FLOW_W             = 16;
    localparam int unsigned SIZE_W             = 8;
    localparam int unsigned CELL_W             = 14;
    localparam int unsigned CFG_IDX_W          = 2;
    localparam int unsigned CFG_DATA_W         = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PRESENT = 2'd2;

    // Request codes.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_POINT = 2'd1;
    localparam logic [1:0] REQ_BOX   = 2'd2;

    // Sample positions in twentieths of the box, and the point position.
    localparam int unsigned NUM_SAMPLES = 5;
    localparam int unsigned SAMPLE_W    = 3;
    localparam logic [4:0]  POS_POINT   = 5'd20;
    localparam logic [4:0]  POS_FULL    = 5'd20;

    // Sample grid index arithmetic widths.
    localparam int unsigned NUM_W  = 22;
    localparam int unsigned SC_W   = NUM_W + SIZE_W;
    localparam int unsigned T_W    = SC_W - COORD_FRAC_BITS;
    localparam int unsigned RECIP_SHIFT = 20;
    localparam logic [15:0] RecipTwenty = 16'd52429;
    localparam int unsigned RC_W   = T_W + 16;
    localparam logic [SC_W-1:0] HALF_CELL = SC_W'(10) << COORD_FRAC_BITS;

    // Flow sum and divider widths.
    localparam int unsigned ACC_W       = 20;
    localparam int unsigned SHIFT_POINT = COORD_FRAC_BITS - 7;
    localparam int unsigned SHIFT_BOX   = COORD_FRAC_BITS - 10;
    localparam int unsigned DIV_W       = ACC_W + SHIFT_POINT;
    localparam int unsigned OUT_CALC_W  = DIV_W + 1;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [CELL_W-1:0]        cell_index;
        logic signed [FLOW_W-1:0] flow_x;
        logic signed [FLOW_W-1:0] flow_y;
        logic [COORD_W-1:0]       coord_x0;
        logic [COORD_W-1:0]       coord_y0;
        logic [COORD_W-1:0]       coord_x1;
        logic [COORD_W-1:0]       coord_y1;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] out_x0;
        logic [COORD_W-1:0] out_y0;
        logic [COORD_W-1:0] out_x1;
        logic [COORD_W-1:0] out_y1;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NUM,
        ST_SCALE,
        ST_RECIP,
        ST_ADDR,
        ST_READ,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                load_req;
        logic                mem_write;
        logic                step_num;
        logic                step_scale;
        logic                step_recip;
        logic                step_addr;
        logic                step_read;
        logic                step_acc;
        logic                div_start;
        logic                out_load;
        logic [SAMPLE_W-1:0] sample;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_req;
        logic       in_active;
        logic       is_box;
        logic       div_busy;
        logic       out_free;
    } t_status;

    // Horizontal sample position in twentieths.
    function automatic logic [4:0] sample_ax(input logic [SAMPLE_W-1:0] idx);
        logic [4:0] a;
        unique case (idx)
            3'd1:    a = 5'd7;
            3'd2:    a = 5'd13;
            default: a = 5'd10;
        endcase
        return a;
    endfunction

    // Vertical sample position in twentieths.
    function automatic logic [4:0] sample_ay(input logic [SAMPLE_W-1:0] idx);
        logic [4:0] a;
        unique case (idx)
            3'd3:    a = 5'd7;
            3'd4:    a = 5'd13;
            default: a = 5'd10;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

>>> hdl/fgbp_divider.sv
`default_nettype none
module fgbp_divider #(
    parameter int unsigned DIVIDEND_W = 29,
    parameter int unsigned DIVISOR_W  = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]         i_divisor,
    output logic                              o_busy,
    output logic signed [DIVIDEND_W-1:0]      o_quotient
);
    localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy, n_busy;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [DIVIDEND_W-1:0] r_mag, n_mag;
    logic [DIVISOR_W:0]    r_rem, n_rem;
    logic                  r_neg, n_neg;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  q_bit;

    // One quotient bit per cycle, restoring, on the magnitude.
    always_comb begin
        rem_sh  = {r_rem[DIVISOR_W-1:0], r_mag[DIVIDEND_W-1]};
        q_bit   = (rem_sh >= {1'b0, i_divisor});
        n_busy  = r_busy;
        n_count = r_count;
        n_mag   = r_mag;
        n_rem   = r_rem;
        n_neg   = r_neg;
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = CNT_W'(DIVIDEND_W);
            n_neg   = i_dividend[DIVIDEND_W-1];
            n_mag   = i_dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-i_dividend)
                                               : DIVIDEND_W'(i_dividend);
            n_rem   = '0;
        end else if (r_busy) begin
            n_rem   = q_bit ? rem_sh - {1'b0, i_divisor} : rem_sh;
            n_mag   = {r_mag[DIVIDEND_W-2:0], q_bit};
            n_count = r_count - 1'b1;
            if (r_count == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_neg <= n_neg;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? -$signed(r_mag) : $signed(r_mag);
endmodule
`default_nettype wire

>>> hdl/fgbp_ctrl.sv
`default_nettype none
module fgbp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire fgbp_pkg::t_status i_status,
    output fgbp_pkg::t_cmd        o_cmd
);
    import fgbp_pkg::*;

    t_state              r_state, n_state;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic                last_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sample <= '0;
        end else begin
            r_state  <= n_state;
            r_sample <= n_sample;
        end
    end

    assign last_sample = i_status.is_box ? (r_sample == SAMPLE_W'(NUM_SAMPLES - 1))
                                         : 1'b1;

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_sample = r_sample;
        o_cmd    = '0;
        o_cmd.sample = r_sample;
        o_in_stall   = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_sample = '0;
                    if (i_status.in_req == REQ_WRITE) begin
                        o_cmd.mem_write = 1'b1;
                    end else if (i_status.in_req == REQ_POINT ||
                                 i_status.in_req == REQ_BOX) begin
                        o_cmd.load_req = 1'b1;
                        n_state = i_status.in_active ? ST_NUM : ST_OUT;
                    end
                end
            end
            ST_NUM:   begin o_cmd.step_num   = 1'b1; n_state = ST_SCALE; end
            ST_SCALE: begin o_cmd.step_scale = 1'b1; n_state = ST_RECIP; end
            ST_RECIP: begin o_cmd.step_recip = 1'b1; n_state = ST_ADDR;  end
            ST_ADDR:  begin o_cmd.step_addr  = 1'b1; n_state = ST_READ;  end
            ST_READ:  begin o_cmd.step_read  = 1'b1; n_state = ST_ACC;   end
            ST_ACC: begin
                o_cmd.step_acc = 1'b1;
                if (last_sample) begin
                    n_state = ST_DIV_START;
                end else begin
                    n_sample = r_sample + 1'b1;
                    n_state  = ST_NUM;
                end
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/fgbp_datapath.sv
`default_nettype none
module fgbp_datapath #(
    parameter int unsigned MAX_GRID_CELLS = fgbp_pkg::MAX_GRID_CELLS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fgbp_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output fgbp_pkg::t_out_item                o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [fgbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fgbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire fgbp_pkg::t_cmd                i_cmd,
    output fgbp_pkg::t_status                  o_status
);
    import fgbp_pkg::*;

    localparam int unsigned AW = $clog2(MAX_GRID_CELLS);

    // Flow table, x in the low half and y in the high half.
    logic [2*FLOW_W-1:0] mem [MAX_GRID_CELLS];

    logic [SIZE_W-1:0]      r_gw, r_gh;
    logic                   r_ref;
    t_in_item               r_req;
    logic                   r_use;
    logic [NUM_W-1:0]       r_num_x, r_num_y;
    logic [SC_W-1:0]        r_sc_x, r_sc_y;
    logic [RC_W-1:0]        r_rc_x, r_rc_y;
    logic [AW-1:0]          r_addr;
    logic [2*FLOW_W-1:0]    r_rd;
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   is_box;
    logic [4:0]             ax, ay;
    logic [SIZE_W-1:0]      ix, iy;
    logic [SIZE_W+8:0]      offs;
    logic signed [ACC_W-1:0] fx_ext, fy_ext;
    logic signed [DIV_W-1:0] div_x, div_y, q_x, q_y, dx, dy;
    logic                   busy_x, busy_y;
    logic                   out_free;

    assign is_box = (r_req.req_type == REQ_BOX);

    // Clamp a rounded grid index to the last row or column.
    function automatic logic [SIZE_W-1:0] clamp_idx(input logic [RC_W-1:0] rc,
                                                    input logic [SIZE_W-1:0] size);
        logic [RC_W-RECIP_SHIFT-1:0] q;
        logic [SIZE_W-1:0]           r;
        q = rc[RC_W-1:RECIP_SHIFT];
        if (size == '0) begin
            r = '0;
        end else if (q > (RC_W-RECIP_SHIFT)'(size - 1'b1)) begin
            r = size - 1'b1;
        end else begin
            r = q[SIZE_W-1:0];
        end
        return r;
    endfunction

    // Subtract the delta from a coordinate and clamp to zero..one.
    function automatic logic [COORD_W-1:0] clamp_out(input logic [COORD_W-1:0] c,
                                                     input logic signed [DIV_W-1:0] d);
        logic signed [OUT_CALC_W-1:0] v;
        logic [COORD_W-1:0]           r;
        v = $signed({{(OUT_CALC_W-COORD_W){1'b0}}, c}) - OUT_CALC_W'(d);
        if (v < 0) begin
            r = '0;
        end else if (v > $signed(OUT_CALC_W'(1) <<< COORD_FRAC_BITS)) begin
            r = COORD_W'(1) << COORD_FRAC_BITS;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw  <= '0;
            r_gh  <= '0;
            r_ref <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_gw  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_gh  <= i_cfg_data;
                CFG_REF_PRESENT: r_ref <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Table write on a write transfer, registered read during a query.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            mem[AW'(i_in_data.cell_index)] <= {i_in_data.flow_y, i_in_data.flow_x};
        end
        if (i_cmd.step_read) begin
            r_rd <= mem[r_addr];
        end
    end

    // Sample position in twentieths; a point sits at the full weight of coord 0.
    always_comb begin
        ax = is_box ? sample_ax(i_cmd.sample) : POS_POINT;
        ay = is_box ? sample_ay(i_cmd.sample) : POS_POINT;
        ix = clamp_idx(r_rc_x, r_gw);
        iy = clamp_idx(r_rc_y, r_gh);
        offs = {9'd0, ix} + (SIZE_W+9)'(iy * r_gw);
        fx_ext = ACC_W'($signed(r_rd[FLOW_W-1:0]));
        fy_ext = ACC_W'($signed(r_rd[2*FLOW_W-1:FLOW_W]));
    end

    // Query datapath: grid index, table address, weighted flow sum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= i_in_data;
            r_use   <= (r_gw != '0) && r_ref;
            r_acc_x <= '0;
            r_acc_y <= '0;
        end
        if (i_cmd.step_num) begin
            r_num_x <= NUM_W'(ax * r_req.coord_x0) + NUM_W'((POS_FULL - ax) * r_req.coord_x1);
            r_num_y <= NUM_W'(ay * r_req.coord_y0) + NUM_W'((POS_FULL - ay) * r_req.coord_y1);
        end
        if (i_cmd.step_scale) begin
            r_sc_x <= SC_W'(r_num_x * r_gw) + HALF_CELL;
            r_sc_y <= SC_W'(r_num_y * r_gh) + HALF_CELL;
        end
        // Division by twenty through a reciprocal; exact over this range.
        if (i_cmd.step_recip) begin
            r_rc_x <= RC_W'(r_sc_x[SC_W-1:COORD_FRAC_BITS] * RecipTwenty);
            r_rc_y <= RC_W'(r_sc_y[SC_W-1:COORD_FRAC_BITS] * RecipTwenty);
        end
        if (i_cmd.step_addr) begin
            r_addr <= AW'(offs);
        end
        if (i_cmd.step_acc) begin
            if (is_box && i_cmd.sample == '0) begin
                r_acc_x <= r_acc_x + (fx_ext <<< 2);
                r_acc_y <= r_acc_y + (fy_ext <<< 2);
            end else begin
                r_acc_x <= r_acc_x + fx_ext;
                r_acc_y <= r_acc_y + fy_ext;
            end
        end
    end

    // Scale the flow sum before the division by the grid size.
    assign div_x = is_box ? (DIV_W'(r_acc_x) <<< SHIFT_BOX) : (DIV_W'(r_acc_x) <<< SHIFT_POINT);
    assign div_y = is_box ? (DIV_W'(r_acc_y) <<< SHIFT_BOX) : (DIV_W'(r_acc_y) <<< SHIFT_POINT);

    fgbp_divider #(.DIVIDEND_W(DIV_W), .DIVISOR_W(SIZE_W)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_x),
        .i_divisor  (r_gw),
        .o_busy     (busy_x),
        .o_quotient (q_x)
    );

    fgbp_divider #(.DIVIDEND_W(DIV_W), .DIVISOR_W(SIZE_W)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_y),
        .i_divisor  (r_gh),
        .o_busy     (busy_y),
        .o_quotient (q_y)
    );

    // No grid or no reference gives a zero delta; zero height gives a zero vertical delta.
    assign dx = r_use ? q_x : '0;
    assign dy = (r_use && r_gh != '0) ? q_y : '0;

    // Output register, free when empty or when its result leaves now.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.out_x0 <= clamp_out(r_req.coord_x0, dx);
            r_out.out_y0 <= clamp_out(r_req.coord_y0, dy);
            r_out.out_x1 <= is_box ? clamp_out(r_req.coord_x1, dx) : '0;
            r_out.out_y1 <= is_box ? clamp_out(r_req.coord_y1, dy) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_status.in_req    = i_in_data.req_type;
    assign o_status.in_active = (r_gw != '0) && r_ref;
    assign o_status.is_box    = is_box;
    assign o_status.div_busy  = busy_x || busy_y;
    assign o_status.out_free  = out_free;
endmodule
`default_nettype wire

>>> hdl/flow_grid_box_predictor.sv
`default_nettype none
// Channel   Direction  Signals                              Transfer when
// in        input      i_in_valid, o_in_stall, i_in_data    valid high, stall low
// out       output     o_out_valid, i_out_stall, o_out_data valid high, stall low
// cfg       input      i_cfg_we, i_cfg_idx, i_cfg_data      write enable high
//
// A flow write is written to the table from ST_IDLE. A query steps each of its samples
// through ST_NUM, ST_SCALE, ST_RECIP, ST_ADDR, ST_READ and ST_ACC on one shared index and
// table-read path (one sample for a point, five for a box), then starts the serial
// dividers and waits for them; with no grid or no reference it goes straight to ST_OUT.
// A result may also wait in ST_OUT for a full output register.
// Reset is synchronous, active low; the flow table has no reset.
// The output register lets the next item enter while a result waits on i_out_stall.
module flow_grid_box_predictor #(
    parameter int unsigned MAX_GRID_CELLS = fgbp_pkg::MAX_GRID_CELLS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire fgbp_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output fgbp_pkg::t_out_item                o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [fgbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fgbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fgbp_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    fgbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Table, arithmetic and output register.
    fgbp_datapath #(.MAX_GRID_CELLS(MAX_GRID_CELLS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );
endmodule
`default_nettype wire

>>> bench/fgbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fgbp_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire fgbp_pkg::t_in_item                i_in_data,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire fgbp_pkg::t_out_item               i_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [fgbp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fgbp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                     o_pending,
    output int                                     o_results,
    output int                                     o_errors
);
    import fgbp_pkg::*;

    localparam int unsigned TABLE_DEPTH = 16384;
    localparam longint ONE_Q16 = longint'(1) << COORD_FRAC_BITS;

    // Shadow copy of the flow grid and of the registers.
    logic [31:0]       flow_grid [TABLE_DEPTH];
    logic [SIZE_W-1:0] grid_cols;
    logic [SIZE_W-1:0] grid_rows;
    logic              ref_on;
    t_out_item         expected_boxes [$];

    assign o_pending = expected_boxes.size();

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_errors++;
    endtask

    // Horizontal and vertical sample fractions in twentieths.
    function automatic longint unsigned frac_x(input int k);
        case (k)
            1:       return 7;
            2:       return 13;
            default: return 10;
        endcase
    endfunction

    function automatic longint unsigned frac_y(input int k);
        case (k)
            3:       return 7;
            4:       return 13;
            default: return 10;
        endcase
    endfunction

    // Rounded grid index of a sample point, clamped to the grid.
    function automatic longint unsigned grid_index(input longint unsigned c0,
            input longint unsigned c1, input longint unsigned a, input longint unsigned size);
        longint unsigned num;
        longint unsigned idx;
        if (size == 0) return 0;
        num = a * c0 + (20 - a) * c1;
        idx = (num * size + 10 * ONE_Q16) / (20 * ONE_Q16);
        if (idx > size - 1) idx = size - 1;
        return idx;
    endfunction

    function automatic logic [31:0] grid_cell(input longint unsigned ix,
            input longint unsigned iy);
        return flow_grid[(ix + iy * grid_cols) % TABLE_DEPTH];
    endfunction

    // Normalized delta, truncated toward zero.
    function automatic longint flow_delta(input longint sum, input longint wdiv,
            input longint size);
        if (size == 0) return 0;
        return (sum * ONE_Q16) / (wdiv * 128 * size);
    endfunction

    function automatic logic [COORD_W-1:0] clamp_unit(input longint v);
        if (v < 0) v = 0;
        if (v > ONE_Q16) v = ONE_Q16;
        return COORD_W'(v);
    endfunction

    function automatic t_out_item predict_box(input t_in_item it);
        t_out_item   res;
        longint      sx;
        longint      sy;
        longint      dx;
        longint      dy;
        logic [31:0] c;
        bit          active;
        sx = 0;
        sy = 0;
        dx = 0;
        dy = 0;
        active = (grid_cols != 0) && ref_on;
        if (active && it.req_type == REQ_POINT) begin
            c = grid_cell(grid_index(it.coord_x0, 0, 20, grid_cols),
                          grid_index(it.coord_y0, 0, 20, grid_rows));
            dx = flow_delta(longint'($signed(c[15:0])), 1, grid_cols);
            dy = flow_delta(longint'($signed(c[31:16])), 1, grid_rows);
        end else if (active) begin
            for (int k = 0; k < 5; k++) begin
                c = grid_cell(grid_index(it.coord_x0, it.coord_x1, frac_x(k), grid_cols),
                              grid_index(it.coord_y0, it.coord_y1, frac_y(k), grid_rows));
                sx += (k == 0 ? 4 : 1) * longint'($signed(c[15:0]));
                sy += (k == 0 ? 4 : 1) * longint'($signed(c[31:16]));
            end
            dx = flow_delta(sx, 8, grid_cols);
            dy = flow_delta(sy, 8, grid_rows);
        end
        res.out_x0 = clamp_unit(longint'(it.coord_x0) - dx);
        res.out_y0 = clamp_unit(longint'(it.coord_y0) - dy);
        if (it.req_type == REQ_POINT) begin
            res.out_x1 = '0;
            res.out_y1 = '0;
        end else begin
            res.out_x1 = clamp_unit(longint'(it.coord_x1) - dx);
            res.out_y1 = clamp_unit(longint'(it.coord_y1) - dy);
        end
        return res;
    endfunction

    // Track registers and table writes, predict on each query transfer, compare on each output transfer.
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            grid_cols <= '0;
            grid_rows <= '0;
            ref_on    <= 1'b0;
            expected_boxes.delete();
            o_errors  = 0;
            o_results = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.req_type == REQ_WRITE)
                    flow_grid[i_in_data.cell_index] <= {i_in_data.flow_y, i_in_data.flow_x};
                else if (i_in_data.req_type == REQ_POINT || i_in_data.req_type == REQ_BOX)
                    expected_boxes.push_back(predict_box(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_boxes.size() == 0) begin
                    report("result transfer with nothing expected");
                end else begin
                    exp_item = expected_boxes.pop_front();
                    if (i_out_data.out_x0 !== exp_item.out_x0)
                        report($sformatf("out_x0 %0d, expected %0d",
                                         i_out_data.out_x0, exp_item.out_x0));
                    if (i_out_data.out_y0 !== exp_item.out_y0)
                        report($sformatf("out_y0 %0d, expected %0d",
                                         i_out_data.out_y0, exp_item.out_y0));
                    if (i_out_data.out_x1 !== exp_item.out_x1)
                        report($sformatf("out_x1 %0d, expected %0d",
                                         i_out_data.out_x1, exp_item.out_x1));
                    if (i_out_data.out_y1 !== exp_item.out_y1)
                        report($sformatf("out_y1 %0d, expected %0d",
                                         i_out_data.out_y1, exp_item.out_y1));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_WIDTH:  grid_cols <= i_cfg_data;
                    CFG_GRID_HEIGHT: grid_rows <= i_cfg_data;
                    CFG_REF_PRESENT: ref_on    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import fgbp_pkg::*;

    localparam int unsigned PRELOAD_CELLS = 256;
    localparam int QUIET_CYCLES = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    results;
    int                    errors;
    int                    stall_left;
    bit                    burst;
    int                    sent;
    logic [SIZE_W-1:0]     cur_cols;
    logic [SIZE_W-1:0]     cur_rows;

    flow_grid_box_predictor i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    fgbp_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_pending(pending), .o_results(results), .o_errors(errors)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Receiver: each result waits under i_out_stall for a random draw before its transfer.
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid) begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= (stall_left > 1);
            end else if (!out_stall) begin
                draw = burst ? 0 : $urandom_range(0, 10);
                stall_left <= draw;
                out_stall  <= (draw > 0);
            end
        end
    end

    // One input transfer after an idle gap of the given length.
    task automatic send_item(input t_in_item it, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        sent++;
    endtask

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    // Register writes happen only once the block has drained.
    task automatic set_grid(input int cols, input int rows, input bit ref_bit);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_GRID_WIDTH;
        cfg_data <= CFG_DATA_W'(cols);
        @(posedge i_clk);
        cfg_idx  <= CFG_GRID_HEIGHT;
        cfg_data <= CFG_DATA_W'(rows);
        @(posedge i_clk);
        cfg_idx  <= CFG_REF_PRESENT;
        cfg_data <= CFG_DATA_W'(ref_bit);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_cols = CFG_DATA_W'(cols);
        cur_rows = CFG_DATA_W'(rows);
    endtask

    function automatic logic [COORD_W-1:0] draw_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COORD_W'(1 << COORD_FRAC_BITS);
            2:       return COORD_W'($urandom);
            default: return COORD_W'($urandom_range(0, 1 << COORD_FRAC_BITS));
        endcase
    endfunction

    function automatic t_in_item draw_item();
        t_in_item it;
        int       cells;
        int       pick;
        it.flow_x   = FLOW_W'($urandom);
        it.flow_y   = FLOW_W'($urandom);
        it.coord_x0 = draw_coord();
        it.coord_y0 = draw_coord();
        it.coord_x1 = draw_coord();
        it.coord_y1 = draw_coord();
        cells = (cur_cols == 0 ? 1 : cur_cols) * (cur_rows == 0 ? 1 : cur_rows);
        it.cell_index = ($urandom_range(0, 3) == 0) ? CELL_W'($urandom)
                                                    : CELL_W'($urandom_range(0, cells - 1));
        pick = $urandom_range(0, 19);
        if (pick < 6)       it.req_type = REQ_WRITE;
        else if (pick < 11) it.req_type = REQ_POINT;
        else if (pick < 19) it.req_type = REQ_BOX;
        else                it.req_type = 2'd3;
        // Mostly well-formed boxes, the rest left as drawn.
        if (it.req_type == REQ_BOX && pick < 17) begin
            it.coord_x0 = COORD_W'($urandom_range(0, 1 << COORD_FRAC_BITS));
            it.coord_y0 = COORD_W'($urandom_range(0, 1 << COORD_FRAC_BITS));
            it.coord_x1 = COORD_W'($urandom_range(it.coord_x0, 1 << COORD_FRAC_BITS));
            it.coord_y1 = COORD_W'($urandom_range(it.coord_y0, 1 << COORD_FRAC_BITS));
        end
        return it;
    endfunction

    function automatic t_in_item make_item(input logic [1:0] req, input int cell_no,
            input int fx, input int fy, input int x0, input int y0, input int x1,
            input int y1);
        t_in_item it;
        it.req_type   = req;
        it.cell_index = CELL_W'(cell_no);
        it.flow_x     = FLOW_W'(fx);
        it.flow_y     = FLOW_W'(fy);
        it.coord_x0   = COORD_W'(x0);
        it.coord_y0   = COORD_W'(y0);
        it.coord_x1   = COORD_W'(x1);
        it.coord_y1   = COORD_W'(y1);
        return it;
    endfunction

    // Stimulus: preload the grid, directed items, then random phases.
    initial begin
        int cols_list [7];
        int rows_list [7];
        bit refs_list [7];
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_GRID_WIDTH;
        cfg_data <= '0;
        burst    = 1'b1;
        sent     = 0;
        cur_cols = '0;
        cur_rows = '0;
        // Every setting spans at most PRELOAD_CELLS cells.
        cols_list = '{128, 0, 1, 128, 5, 16, 2};
        rows_list = '{2, 128, 1, 0, 3, 16, 128};
        refs_list = '{1, 1, 1, 1, 0, 1, 1};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every cell a query can reach gets a value first.
        for (int i = 0; i < PRELOAD_CELLS; i++)
            send_item(make_item(REQ_WRITE, i, $urandom, $urandom, 0, 0, 0, 0), 0);

        // Queries with the grid still off after reset.
        burst = 1'b0;
        send_item(make_item(REQ_POINT, 0, 0, 0, 32768, 65536, 0, 0), draw_gap());
        send_item(make_item(REQ_BOX, 0, 0, 0, 0, 0, 65536, 65536), draw_gap());

        set_grid(cols_list[0], rows_list[0], refs_list[0]);
        send_item(make_item(REQ_WRITE, 0, -32768, 32767, 0, 0, 0, 0), draw_gap());
        send_item(make_item(REQ_WRITE, 255, 32767, -32768, 0, 0, 0, 0), draw_gap());
        send_item(make_item(REQ_WRITE, 192, -1, 1, 0, 0, 0, 0), draw_gap());
        send_item(make_item(REQ_POINT, 0, 0, 0, 0, 0, 0, 0), draw_gap());
        send_item(make_item(REQ_POINT, 0, 0, 0, 65536, 65536, 0, 0), draw_gap());
        send_item(make_item(REQ_POINT, 0, 0, 0, 131071, 131071, 131071, 131071),
                  draw_gap());
        send_item(make_item(REQ_POINT, 0, 0, 0, 32768, 32768, 0, 0), draw_gap());
        send_item(make_item(REQ_BOX, 0, 0, 0, 0, 0, 0, 0), draw_gap());
        send_item(make_item(REQ_BOX, 0, 0, 0, 65536, 65536, 65536, 65536), draw_gap());
        send_item(make_item(REQ_BOX, 0, 0, 0, 0, 0, 65536, 65536), draw_gap());
        send_item(make_item(REQ_BOX, 0, 0, 0, 131071, 131071, 131071, 131071),
                  draw_gap());
        send_item(make_item(REQ_BOX, 0, 0, 0, 65536, 65536, 0, 0), draw_gap());
        send_item(make_item(2'd3, 5, 7, 7, 100, 100, 200, 200), draw_gap());
        send_item(make_item(REQ_POINT, 0, 0, 0, 1000, 64000, 0, 0), draw_gap());

        // Random phases, each under its own grid setting.
        for (int p = 0; p < 7; p++) begin
            set_grid(cols_list[p], rows_list[p], refs_list[p]);
            for (int n = 0; n < 100; n++) begin
                if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
                send_item(draw_item(), draw_gap());
            end
            burst = 1'b0;
        end
        in_valid <= 1'b0;

        // Drain and let the block settle.
        while (pending != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        $display("%0d input transfers, %0d results checked", sent, results);
        $display("seven grid settings, including no grid, no reference and zero height");
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> flow_grid_box_predictor.f
hdl/fgbp_pkg.sv
hdl/fgbp_divider.sv
hdl/fgbp_ctrl.sv
hdl/fgbp_datapath.sv
hdl/flow_grid_box_predictor.sv
bench/fgbp_checker.sv
bench/tb.sv
